// ===== hdl/audio_jitter_buffer_peer_control_assert.svh =====
// ----------------------------------------------------------------------------
// audio jitter buffer peer control assertion macros
// shorthand for clocked implication checks disabled while the active-low reset is low
// ----------------------------------------------------------------------------
`ifndef AUDIO_JITTER_BUFFER_PEER_CONTROL_ASSERT_SVH
`define AUDIO_JITTER_BUFFER_PEER_CONTROL_ASSERT_SVH

// same-cycle implication
`define AJB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AJB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ajb_pkg.sv =====
// ----------------------------------------------------------------------------
// ajb_pkg
// shared constants and codes of the audio jitter buffer peer control
// ----------------------------------------------------------------------------
package ajb_pkg;

    localparam int SLOTS         = 4;
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int FRAME_SAMPLES = 160;

    localparam int IN_TDATA_W  = 48;   // connection, frame_number, audio_pos
    localparam int OUT_TDATA_W = 64;   // 57 used bits, zero padded

    // request types
    localparam logic [1:0] REQ_CONNECT    = 2'd0;
    localparam logic [1:0] REQ_DISCONNECT = 2'd1;
    localparam logic [1:0] REQ_FRAME      = 2'd2;
    localparam logic [1:0] REQ_LOST       = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LAT_LOW    = 2'd0;
    localparam logic [1:0] CFG_LAT_TARGET = 2'd1;
    localparam logic [1:0] CFG_LAT_HIGH   = 2'd2;
    localparam logic [1:0] CFG_MAX_LOST   = 2'd3;

    localparam logic [7:0] CNT_NORMAL = 8'(FRAME_SAMPLES);
    localparam logic [7:0] CNT_INSERT = 8'(FRAME_SAMPLES + 1);
    localparam logic [7:0] CNT_DROP   = 8'(FRAME_SAMPLES - 1);

    localparam logic [4:0] LOST_SAT = 5'd31;

endpackage

// ===== hdl/audio_jitter_buffer_peer_control.sv =====
// ----------------------------------------------------------------------------
// audio_jitter_buffer_peer_control
// peer table and write scheduling of an audio jitter buffer with drift
// compensation
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request: tuser = req_type, tdata = connection,
//   frame_number, audio_pos. m_axis carries result items: tuser = out_kind,
//   tlast marks the final result of a request, tdata = slot, write_position,
//   sample_count, use_previous, out_frame_number, atten_shift, jumped.
//   the cfg channel writes the low, target and high latency and the lost
//   frame limit by index; it is always ready and is meant for idle time.
// sequencing
//   one request at a time through a small sequencer around a single 32-bit
//   add/subtract unit. each audio write takes up to 5 adder passes (latency,
//   jump check, min check, max check or jump position, next position); a
//   frame with one skipped index can show a concealment write before its own
//   write. s_axis_tready is high only while the sequencer is idle; the adder
//   is the limit on rate.
// reset and stall
//   synchronous active-low reset frees every slot and loads the default
//   registers (160, 320, 480, 16). a stalled m_axis holds its result in the
//   output register; the sequencer waits before loading another one, but a
//   new request is taken as soon as the last result sits in that register.
// ----------------------------------------------------------------------------
module audio_jitter_buffer_peer_control (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ajb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // connection, frame_number, audio_pos
    input  logic [1:0]                       s_axis_tuser,  // req_type
    // result channel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ajb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // slot, write_position,
                                                            // sample_count, use_previous,
                                                            // out_frame_number,
                                                            // atten_shift, jumped
    output logic [1:0]                       m_axis_tuser,  // out_kind
    output logic                             m_axis_tlast,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);
    import ajb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CONN,
        ST_LOST,
        ST_FRAME,
        ST_LAT,
        ST_JMP,
        ST_MIN,
        ST_MAX,
        ST_POS,
        ST_EMIT
    } t_state;

    // sequencer state
    t_state              r_state, n_state;

    // configuration
    logic [15:0]         r_min_lat, n_min_lat;
    logic [15:0]         r_tgt_lat, n_tgt_lat;
    logic [15:0]         r_max_lat, n_max_lat;
    logic [4:0]          r_max_lost, n_max_lost;

    // peer table
    logic                r_active [SLOTS];
    logic                n_active [SLOTS];
    logic [7:0]          r_handle [SLOTS];
    logic [7:0]          n_handle [SLOTS];
    logic [7:0]          r_prev   [SLOTS];
    logic [7:0]          n_prev   [SLOTS];
    logic [4:0]          r_lost   [SLOTS];
    logic [4:0]          n_lost   [SLOTS];
    logic [31:0]         r_wp     [SLOTS];
    logic [31:0]         n_wp     [SLOTS];

    // captured request
    logic [1:0]          r_req, n_req;
    logic [7:0]          r_conn, n_conn;
    logic [7:0]          r_fnum, n_fnum;
    logic [31:0]         r_apos, n_apos;

    // working registers
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                r_hit, n_hit;
    logic                r_then_frame, n_then_frame;
    logic                r_usep, n_usep;
    logic                r_jumped, n_jumped;
    logic [31:0]         r_lat, n_lat;
    logic [31:0]         r_pos, n_pos;
    logic [7:0]          r_cnt, n_cnt;

    // output register
    logic                r_m_valid, n_m_valid;
    logic [1:0]          r_out_kind, n_out_kind;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [31:0]         r_out_pos, n_out_pos;
    logic [7:0]          r_out_cnt, n_out_cnt;
    logic                r_out_usep, n_out_usep;
    logic [7:0]          r_out_fnum, n_out_fnum;
    logic [4:0]          r_out_shift, n_out_shift;
    logic                r_out_jumped, n_out_jumped;
    logic                r_out_last, n_out_last;

    // shared adder
    logic [31:0]         w_a, w_b;
    logic                w_sub;
    logic [32:0]         w_sum;
    logic                w_carry;

    // table lookup
    logic                w_free_found, w_peer_found;
    logic [SLOT_W-1:0]   w_free_idx, w_peer_idx;
    logic [7:0]          w_delta;
    logic [4:0]          w_lost_inc;
    logic [4:0]          w_cur_lost;
    logic                w_out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {7'b0, r_out_jumped, r_out_shift, r_out_fnum, r_out_usep,
                            r_out_cnt, r_out_pos, r_out_slot};

    // lowest idle slot and lowest active slot holding the handle
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        w_peer_found = 1'b0;
        w_peer_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = SLOT_W'(i);
            end
            if (r_active[i] && (r_handle[i] == r_conn)) begin
                w_peer_found = 1'b1;
                w_peer_idx   = SLOT_W'(i);
            end
        end
    end

    assign w_delta    = r_fnum - r_prev[w_peer_idx];
    assign w_cur_lost = r_lost[r_slot];
    assign w_lost_inc = (w_cur_lost == LOST_SAT) ? LOST_SAT : w_cur_lost + 5'd1;

    // operand selection of the shared add/subtract unit
    always_comb begin
        w_a   = r_apos;
        w_b   = {16'b0, r_tgt_lat};
        w_sub = 1'b0;
        unique case (r_state)
            ST_LAT: begin
                w_a   = r_wp[r_slot];
                w_b   = r_apos;
                w_sub = 1'b1;
            end
            ST_JMP: begin
                // twice the high latency minus the latency, borrow means a jump
                w_a   = {15'b0, r_max_lat, 1'b0};
                w_b   = r_lat;
                w_sub = 1'b1;
            end
            ST_MIN: begin
                w_a   = r_lat;
                w_b   = {16'b0, r_min_lat};
                w_sub = 1'b1;
            end
            ST_MAX: begin
                w_a   = {16'b0, r_max_lat};
                w_b   = r_lat;
                w_sub = 1'b1;
            end
            ST_EMIT: begin
                w_a   = r_pos;
                w_b   = {24'b0, r_cnt};
                w_sub = 1'b0;
            end
            default: begin
                w_a   = r_apos;
                w_b   = {16'b0, r_tgt_lat};
                w_sub = 1'b0;
            end
        endcase
    end

    assign w_sum   = {1'b0, w_a} + {1'b0, w_b ^ {32{w_sub}}} + 33'(w_sub);
    assign w_carry = w_sum[32];

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_min_lat    = r_min_lat;
        n_tgt_lat    = r_tgt_lat;
        n_max_lat    = r_max_lat;
        n_max_lost   = r_max_lost;
        n_active     = r_active;
        n_handle     = r_handle;
        n_prev       = r_prev;
        n_lost       = r_lost;
        n_wp         = r_wp;
        n_req        = r_req;
        n_conn       = r_conn;
        n_fnum       = r_fnum;
        n_apos       = r_apos;
        n_slot       = r_slot;
        n_hit        = r_hit;
        n_then_frame = r_then_frame;
        n_usep       = r_usep;
        n_jumped     = r_jumped;
        n_lat        = r_lat;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_m_valid    = r_m_valid && !m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_pos    = r_out_pos;
        n_out_cnt    = r_out_cnt;
        n_out_usep   = r_out_usep;
        n_out_fnum   = r_out_fnum;
        n_out_shift  = r_out_shift;
        n_out_jumped = r_out_jumped;
        n_out_last   = r_out_last;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LAT_LOW:    n_min_lat  = i_cfg_data;
                CFG_LAT_TARGET: n_tgt_lat  = i_cfg_data;
                CFG_LAT_HIGH:   n_max_lat  = i_cfg_data;
                CFG_MAX_LOST:   n_max_lost = i_cfg_data[4:0];
                default:        n_max_lost = r_max_lost;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_req   = s_axis_tuser;
                    n_conn  = s_axis_tdata[7:0];
                    n_fnum  = s_axis_tdata[15:8];
                    n_apos  = s_axis_tdata[47:16];
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_then_frame = 1'b0;
                n_state      = ST_IDLE;
                unique case (r_req)
                    REQ_CONNECT: begin
                        n_hit   = w_free_found;
                        n_slot  = w_free_idx;
                        n_state = ST_CONN;
                    end
                    REQ_DISCONNECT: begin
                        if (w_peer_found) begin
                            n_active[w_peer_idx] = 1'b0;
                        end
                    end
                    REQ_FRAME: begin
                        n_slot = w_peer_idx;
                        if (w_peer_found && (w_delta != 8'd0)) begin
                            // exactly one index skipped: conceal it first
                            if (w_delta == 8'd2) begin
                                n_then_frame = 1'b1;
                                n_state      = ST_LOST;
                            end else begin
                                n_state = ST_FRAME;
                            end
                        end
                    end
                    REQ_LOST: begin
                        n_slot = w_peer_idx;
                        if (w_peer_found) begin
                            n_state = ST_LOST;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_CONN: begin
                if (w_out_free) begin
                    if (r_hit) begin
                        n_active[r_slot] = 1'b1;
                        n_handle[r_slot] = r_conn;
                        n_prev[r_slot]   = 8'd0;
                        n_lost[r_slot]   = 5'd0;
                        n_wp[r_slot]     = w_sum[31:0];
                    end
                    n_m_valid    = 1'b1;
                    n_out_kind   = r_hit ? KIND_ACCEPT : KIND_REJECT;
                    n_out_slot   = r_hit ? r_slot : '0;
                    n_out_pos    = '0;
                    n_out_cnt    = '0;
                    n_out_usep   = 1'b0;
                    n_out_fnum   = '0;
                    n_out_shift  = '0;
                    n_out_jumped = 1'b0;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_LOST: begin
                n_lost[r_slot] = w_lost_inc;
                n_prev[r_slot] = r_prev[r_slot] + 8'd1;
                n_usep         = 1'b1;
                if (w_lost_inc > r_max_lost) begin
                    n_then_frame = 1'b0;
                    n_state      = r_then_frame ? ST_FRAME : ST_IDLE;
                end else begin
                    n_state = ST_LAT;
                end
            end
            ST_FRAME: begin
                n_lost[r_slot] = 5'd0;
                n_prev[r_slot] = r_fnum;
                n_usep         = 1'b0;
                n_state        = ST_LAT;
            end
            ST_LAT: begin
                n_lat    = w_sum[31:0];
                n_jumped = 1'b0;
                n_state  = ST_JMP;
            end
            ST_JMP: begin
                if (r_lat[31] || !w_carry) begin
                    n_jumped = 1'b1;
                    n_cnt    = CNT_NORMAL;
                    n_state  = ST_POS;
                end else begin
                    n_pos   = r_wp[r_slot];
                    n_state = ST_MIN;
                end
            end
            ST_MIN: begin
                if (!w_carry) begin
                    n_cnt   = CNT_INSERT;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_MAX;
                end
            end
            ST_MAX: begin
                n_cnt   = w_carry ? CNT_NORMAL : CNT_DROP;
                n_state = ST_EMIT;
            end
            ST_POS: begin
                n_pos   = w_sum[31:0];
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_wp[r_slot] = w_sum[31:0];
                    n_m_valid    = 1'b1;
                    n_out_kind   = KIND_WRITE;
                    n_out_slot   = r_slot;
                    n_out_pos    = r_pos;
                    n_out_cnt    = r_cnt;
                    n_out_usep   = r_usep;
                    n_out_fnum   = r_prev[r_slot];
                    n_out_shift  = (w_cur_lost > 5'd1) ? w_cur_lost - 5'd1 : 5'd0;
                    n_out_jumped = r_jumped;
                    n_out_last   = !r_then_frame;
                    n_then_frame = 1'b0;
                    n_state      = r_then_frame ? ST_FRAME : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_min_lat    <= 16'd160;
            r_tgt_lat    <= 16'd320;
            r_max_lat    <= 16'd480;
            r_max_lost   <= 5'd16;
            r_m_valid    <= 1'b0;
            r_then_frame <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_active[i] <= 1'b0;
            end
        end else begin
            r_state      <= n_state;
            r_min_lat    <= n_min_lat;
            r_tgt_lat    <= n_tgt_lat;
            r_max_lat    <= n_max_lat;
            r_max_lost   <= n_max_lost;
            r_m_valid    <= n_m_valid;
            r_then_frame <= n_then_frame;
            r_active     <= n_active;
        end
        r_handle     <= n_handle;
        r_prev       <= n_prev;
        r_lost       <= n_lost;
        r_wp         <= n_wp;
        r_req        <= n_req;
        r_conn       <= n_conn;
        r_fnum       <= n_fnum;
        r_apos       <= n_apos;
        r_slot       <= n_slot;
        r_hit        <= n_hit;
        r_usep       <= n_usep;
        r_jumped     <= n_jumped;
        r_lat        <= n_lat;
        r_pos        <= n_pos;
        r_cnt        <= n_cnt;
        r_out_kind   <= n_out_kind;
        r_out_slot   <= n_out_slot;
        r_out_pos    <= n_out_pos;
        r_out_cnt    <= n_out_cnt;
        r_out_usep   <= n_out_usep;
        r_out_fnum   <= n_out_fnum;
        r_out_shift  <= n_out_shift;
        r_out_jumped <= n_out_jumped;
        r_out_last   <= n_out_last;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `include "audio_jitter_buffer_peer_control_assert.svh"

    // a write always carries one of the three drift counts
    `AJB_ASSERT_NOW(a_write_count, i_clk, i_rst_n,
        r_m_valid && (r_out_kind == KIND_WRITE),
        (r_out_cnt == CNT_NORMAL) || (r_out_cnt == CNT_INSERT) || (r_out_cnt == CNT_DROP),
        "write result with bad sample count")

    // a jump restarts at the nominal frame length
    `AJB_ASSERT_NOW(a_jump_count, i_clk, i_rst_n,
        r_m_valid && r_out_jumped,
        (r_out_kind == KIND_WRITE) && (r_out_cnt == CNT_NORMAL),
        "jump without nominal sample count")

    // a taken request makes the sequencer busy on the next cycle
    `AJB_ASSERT_NEXT(a_busy_after_request, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready,
        !s_axis_tready,
        "request taken while previous one in flight")

    // only a concealment followed by its frame leaves a result without tlast
    `AJB_ASSERT_NOW(a_last_pairing, i_clk, i_rst_n,
        r_m_valid && !r_out_last,
        r_out_usep && (r_out_kind == KIND_WRITE),
        "non-final result that is not a concealment write")

endmodule
